// File: hw/rtl/jsu_pkg.sv
// Shared types, character codes and helper functions for the JSON string unescaper.
package jsu_pkg;

  localparam int unsigned GRP_MAX = 6;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_ESC,
    PH_UHEX,
    PH_XHEX,
    PH_SKIP,
    PH_LOWHEX,
    PH_BADU,
    PH_BADX,
    PH_BADLOW
  } phase_t;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_ESCAPE    = 2'd1;
  localparam logic [1:0] ERR_SURROGATE = 2'd2;
  localparam logic [1:0] ERR_HEX       = 2'd3;

  localparam logic [7:0] C_QUOTE  = 8'h22;
  localparam logic [7:0] C_PLUS   = 8'h2B;
  localparam logic [7:0] C_SLASH  = 8'h2F;
  localparam logic [7:0] C_BSLASH = 8'h5C;
  localparam logic [7:0] C_LC_B   = 8'h62;
  localparam logic [7:0] C_LC_F   = 8'h66;
  localparam logic [7:0] C_LC_N   = 8'h6E;
  localparam logic [7:0] C_LC_R   = 8'h72;
  localparam logic [7:0] C_LC_T   = 8'h74;
  localparam logic [7:0] C_LC_U   = 8'h75;

  localparam logic [15:0] HI_MIN = 16'hD800;
  localparam logic [15:0] HI_MAX = 16'hDBFF;
  localparam logic [15:0] LO_MIN = 16'hDC00;
  localparam logic [15:0] LO_MAX = 16'hDFFF;

  localparam logic [15:0] OFF_PLUS     = 16'd2;
  localparam logic [15:0] OFF_U_END    = 16'd5;
  localparam logic [15:0] OFF_SKIP_END = 16'd7;
  localparam logic [15:0] OFF_X_END    = 16'd10;
  localparam logic [15:0] OFF_LOW_END  = 16'd11;

  localparam logic [15:0] POS_U_HEX   = 16'd2;
  localparam logic [15:0] POS_X_HEX   = 16'd3;
  localparam logic [15:0] POS_LOW_HEX = 16'd8;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } jsu_in_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        out_last;
    logic [1:0]  error_code;
    logic [15:0] error_pos;
  } jsu_out_t;

  typedef struct packed {
    logic [GRP_MAX-1:0][7:0] bytes;
    logic [2:0]              count;
    logic                    data;
    logic                    last;
    logic [1:0]              err;
    logic [15:0]             pos;
  } jsu_group_t;

  typedef struct packed {
    logic [GRP_MAX-1:0][7:0] bytes;
    logic [2:0]              count;
  } jsu_utf8_t;

  // bit 4 set marks a byte that is not a hex digit
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b0, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b0, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  function automatic jsu_utf8_t utf8_encode(input logic [30:0] code);
    jsu_utf8_t r;
    r.bytes = '0;
    if (code < 31'h80) begin
      r.count    = 3'd1;
      r.bytes[0] = {1'b0, code[6:0]};
    end else if (code < 31'h800) begin
      r.count    = 3'd2;
      r.bytes[0] = {3'b110, code[10:6]};
      r.bytes[1] = {2'b10, code[5:0]};
    end else if (code < 31'h10000) begin
      r.count    = 3'd3;
      r.bytes[0] = {4'b1110, code[15:12]};
      r.bytes[1] = {2'b10, code[11:6]};
      r.bytes[2] = {2'b10, code[5:0]};
    end else if (code < 31'h200000) begin
      r.count    = 3'd4;
      r.bytes[0] = {5'b11110, code[20:18]};
      r.bytes[1] = {2'b10, code[17:12]};
      r.bytes[2] = {2'b10, code[11:6]};
      r.bytes[3] = {2'b10, code[5:0]};
    end else if (code < 31'h4000000) begin
      r.count    = 3'd5;
      r.bytes[0] = {6'b111110, code[25:24]};
      r.bytes[1] = {2'b10, code[23:18]};
      r.bytes[2] = {2'b10, code[17:12]};
      r.bytes[3] = {2'b10, code[11:6]};
      r.bytes[4] = {2'b10, code[5:0]};
    end else begin
      r.count    = 3'd6;
      r.bytes[0] = {7'b1111110, code[30]};
      r.bytes[1] = {2'b10, code[29:24]};
      r.bytes[2] = {2'b10, code[23:18]};
      r.bytes[3] = {2'b10, code[17:12]};
      r.bytes[4] = {2'b10, code[11:6]};
      r.bytes[5] = {2'b10, code[5:0]};
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/jsu_chan_if.sv
// Valid/ready channel carrying one payload per transfer.
interface jsu_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/jsu_decoder.sv
// Input register, escape state machine and per-byte decode into a result group.
module jsu_decoder (
  input  logic               clk,
  input  logic               rst,
  input  logic               allow_ext,
  jsu_chan_if.sink           text,
  output logic               grp_valid,
  output jsu_pkg::jsu_group_t grp,
  input  logic               grp_ready
);
  import jsu_pkg::*;

  logic        in_full;
  jsu_in_t     in_q;
  logic        fire;

  phase_t      phase, phase_next;
  logic [31:0] accum, accum_next;
  logic [9:0]  hh, hh_next;
  logic [15:0] index, index_next;
  logic [15:0] start, start_next;
  logic [1:0]  err, err_next;

  logic [7:0]  c;
  logic        last;
  logic [15:0] off;
  logic [4:0]  hex;
  logic        dv;
  logic [31:0] acc_sh;
  logic [20:0] cp;
  logic        raw_en, utf_en;
  logic [7:0]  raw;
  logic [30:0] code;
  logic        fail_en;
  logic [1:0]  fail_code;
  logic [15:0] fail_pos;
  jsu_utf8_t   enc;

  assign fire       = in_full && (grp.count == 3'd0 || grp_ready);
  assign text.ready = !in_full || fire;
  assign grp_valid  = in_full && grp.count != 3'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (text.ready) begin
      in_full <= text.valid;
    end
    if (text.valid && text.ready) begin
      in_q <= text.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      accum <= '0;
      hh    <= '0;
      index <= '0;
      start <= '0;
      err   <= ERR_NONE;
    end else if (fire) begin
      phase <= phase_next;
      accum <= accum_next;
      hh    <= hh_next;
      index <= index_next;
      start <= start_next;
      err   <= err_next;
    end
  end

  always_comb begin
    c      = in_q.in_byte;
    last   = in_q.in_last;
    off    = index - start;
    hex    = hex_digit(c);
    dv     = !hex[4];
    acc_sh = {accum[27:0], hex[3:0]};
    cp     = {1'b0, hh, acc_sh[9:0]} + 21'h10000;

    phase_next = phase;
    accum_next = accum;
    hh_next    = hh;
    start_next = start;
    err_next   = err;
    index_next = index + 16'd1;
    raw_en     = 1'b0;
    raw        = c;
    utf_en     = 1'b0;
    code       = '0;
    fail_en    = 1'b0;
    fail_code  = ERR_ESCAPE;
    fail_pos   = start;

    if (err == ERR_NONE) begin
      unique case (phase)
        PH_IDLE: begin
          if (c == C_BSLASH) begin
            start_next = index;
            phase_next = PH_ESC;
            if (last) begin
              fail_en  = 1'b1;
              fail_pos = index;
            end
          end else begin
            raw_en = 1'b1;
          end
        end
        PH_ESC: begin
          raw_en = 1'b1;
          case (c) inside
            C_QUOTE, C_BSLASH, C_SLASH: raw = c;
            C_LC_B: raw = 8'h08;
            C_LC_F: raw = 8'h0C;
            C_LC_N: raw = 8'h0A;
            C_LC_R: raw = 8'h0D;
            C_LC_T: raw = 8'h09;
            default: raw_en = 1'b0;
          endcase
          if (raw_en) begin
            phase_next = PH_IDLE;
          end else if (c == C_LC_U && !last) begin
            accum_next = '0;
            phase_next = PH_UHEX;
          end else begin
            fail_en = 1'b1;
          end
        end
        PH_UHEX: begin
          if (off == OFF_PLUS && c == C_PLUS) begin
            if (!allow_ext || last) begin
              fail_en = 1'b1;
            end else begin
              accum_next = '0;
              phase_next = PH_XHEX;
            end
          end else begin
            if (dv) begin
              accum_next = acc_sh;
            end else begin
              phase_next = PH_BADU;
            end
            if (off >= OFF_U_END) begin
              if (!dv) begin
                fail_en   = 1'b1;
                fail_code = ERR_HEX;
                fail_pos  = start + POS_U_HEX;
              end else if (acc_sh[15:0] >= HI_MIN && acc_sh[15:0] <= HI_MAX) begin
                hh_next    = acc_sh[9:0];
                phase_next = PH_SKIP;
                if (last) begin
                  fail_en   = 1'b1;
                  fail_code = ERR_SURROGATE;
                end
              end else begin
                utf_en     = 1'b1;
                code       = {15'd0, acc_sh[15:0]};
                phase_next = PH_IDLE;
              end
            end else if (last) begin
              fail_en = 1'b1;
            end
          end
        end
        PH_BADU: begin
          if (off >= OFF_U_END) begin
            fail_en   = 1'b1;
            fail_code = ERR_HEX;
            fail_pos  = start + POS_U_HEX;
          end else if (last) begin
            fail_en = 1'b1;
          end
        end
        PH_XHEX: begin
          if (dv) begin
            accum_next = acc_sh;
          end else begin
            phase_next = PH_BADX;
          end
          if (off >= OFF_X_END) begin
            if (!dv) begin
              fail_en   = 1'b1;
              fail_code = ERR_HEX;
              fail_pos  = start + POS_X_HEX;
            end else if (acc_sh[31]) begin
              fail_en = 1'b1;
            end else begin
              utf_en     = 1'b1;
              code       = acc_sh[30:0];
              phase_next = PH_IDLE;
            end
          end else if (last) begin
            fail_en = 1'b1;
          end
        end
        PH_BADX: begin
          if (off >= OFF_X_END) begin
            fail_en   = 1'b1;
            fail_code = ERR_HEX;
            fail_pos  = start + POS_X_HEX;
          end else if (last) begin
            fail_en = 1'b1;
          end
        end
        PH_SKIP: begin
          if (off >= OFF_SKIP_END) begin
            accum_next = '0;
            phase_next = PH_LOWHEX;
          end
          if (last) begin
            fail_en   = 1'b1;
            fail_code = ERR_SURROGATE;
          end
        end
        PH_LOWHEX: begin
          if (dv) begin
            accum_next = acc_sh;
          end else begin
            phase_next = PH_BADLOW;
          end
          if (off >= OFF_LOW_END) begin
            if (!dv) begin
              fail_en   = 1'b1;
              fail_code = ERR_HEX;
              fail_pos  = start + POS_LOW_HEX;
            end else if (acc_sh[15:0] < LO_MIN || acc_sh[15:0] > LO_MAX) begin
              fail_en   = 1'b1;
              fail_code = ERR_SURROGATE;
            end else begin
              utf_en     = 1'b1;
              code       = {10'd0, cp};
              phase_next = PH_IDLE;
            end
          end else if (last) begin
            fail_en   = 1'b1;
            fail_code = ERR_SURROGATE;
          end
        end
        PH_BADLOW: begin
          if (off >= OFF_LOW_END) begin
            fail_en   = 1'b1;
            fail_code = ERR_HEX;
            fail_pos  = start + POS_LOW_HEX;
          end else if (last) begin
            fail_en   = 1'b1;
            fail_code = ERR_SURROGATE;
          end
        end
        default: phase_next = PH_IDLE;
      endcase
    end

    if (fail_en) begin
      err_next   = fail_code;
      start_next = fail_pos;
      phase_next = PH_IDLE;
    end

    enc       = utf8_encode(code);
    grp.bytes = '0;
    grp.count = 3'd0;
    grp.data  = 1'b1;
    grp.last  = last;
    grp.err   = ERR_NONE;
    grp.pos   = '0;
    if (raw_en) begin
      grp.bytes[0] = raw;
      grp.count    = 3'd1;
    end else if (utf_en) begin
      grp.bytes = enc.bytes;
      grp.count = enc.count;
    end else if (last) begin
      // end marker carrying the held error, if any
      grp.count = 3'd1;
      grp.data  = 1'b0;
      grp.err   = err_next;
      grp.pos   = (err_next != ERR_NONE) ? start_next : 16'd0;
    end

    if (last) begin
      phase_next = PH_IDLE;
      accum_next = '0;
      hh_next    = '0;
      index_next = '0;
      start_next = '0;
      err_next   = ERR_NONE;
    end
  end

endmodule

// File: hw/rtl/jsu_burst_buf.sv
// Result register holding one decoded group and shifting it out a byte per transfer.
module jsu_burst_buf (
  input  logic                clk,
  input  logic                rst,
  input  logic                grp_valid,
  input  jsu_pkg::jsu_group_t grp,
  output logic                grp_ready,
  jsu_chan_if.source          utf8
);
  import jsu_pkg::*;

  logic [2:0] count;
  jsu_group_t held;
  logic       xfer;
  logic       load;

  assign xfer      = utf8.valid && utf8.ready;
  assign grp_ready = count == 3'd0 || (count == 3'd1 && utf8.ready);
  assign load      = grp_valid && grp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (load) begin
      count <= grp.count;
    end else if (xfer) begin
      count <= count - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= grp;
    end else if (xfer) begin
      held.bytes <= {8'h00, held.bytes[GRP_MAX-1:1]};
    end
  end

  assign utf8.valid           = count != 3'd0;
  assign utf8.data.out_byte   = held.bytes[0];
  assign utf8.data.byte_valid = held.data;
  assign utf8.data.out_last   = held.last && count == 3'd1;
  assign utf8.data.error_code = held.err;
  assign utf8.data.error_pos  = held.pos;

endmodule

// File: hw/rtl/json_string_unescaper.sv
// JSON string unescaper top level: configuration register, decoder and result buffer.
// A byte transferred into the input register is decoded from there into the result register,
// from which its first result may transfer. Throughput: one input byte per cycle while the
// output is not stalled, set by the output of one byte per cycle: a byte with results waits
// in the input register until the result register is empty or its group is down to its last byte.
// Reset (synchronous) empties both stages, clears the string state and enables \u+ escapes.
module json_string_unescaper (
  input  logic       clk,
  input  logic       rst,
  jsu_chan_if.sink   text,
  jsu_chan_if.sink   cfg,
  jsu_chan_if.source utf8
);
  import jsu_pkg::*;

  logic       allow_extended_escape;
  logic       grp_valid;
  logic       grp_ready;
  jsu_group_t grp;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      allow_extended_escape <= 1'b1;
    end else if (cfg.valid) begin
      allow_extended_escape <= cfg.data;
    end
  end

  jsu_decoder u_decoder (
    .clk       (clk),
    .rst       (rst),
    .allow_ext (allow_extended_escape),
    .text      (text),
    .grp_valid (grp_valid),
    .grp       (grp),
    .grp_ready (grp_ready)
  );

  jsu_burst_buf u_burst_buf (
    .clk       (clk),
    .rst       (rst),
    .grp_valid (grp_valid),
    .grp       (grp),
    .grp_ready (grp_ready),
    .utf8      (utf8)
  );

`ifndef SYNTHESIS
  a_data_no_error: assert property (@(posedge clk) disable iff (rst)
    utf8.valid && utf8.data.byte_valid |-> utf8.data.error_code == ERR_NONE)
    else $error("data byte carries an error code");

  a_marker_last: assert property (@(posedge clk) disable iff (rst)
    utf8.valid && !utf8.data.byte_valid |-> utf8.data.out_last)
    else $error("end marker without out_last");

  a_group_size: assert property (@(posedge clk) disable iff (rst)
    grp_valid |-> grp.count != 3'd0 && grp.count <= 3'd6)
    else $error("decoded group size out of range");

  a_marker_group: assert property (@(posedge clk) disable iff (rst)
    grp_valid && !grp.data |-> grp.count == 3'd1 && grp.last)
    else $error("end marker group malformed");
`endif

endmodule

// File: sim/unescape_checker.sv
// Checker for the JSON string unescaper: watches its channels, predicts UTF-8 output, compares.
module unescape_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              text_valid,
  input  logic              text_ready,
  input  jsu_pkg::jsu_in_t  text_data,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic              cfg_data,
  input  logic              utf8_valid,
  input  logic              utf8_ready,
  input  jsu_pkg::jsu_out_t utf8_data,
  output int unsigned       mismatches,
  output int unsigned       pending
);
  import jsu_pkg::*;

  logic        ext_en;
  phase_t      phase;
  logic [31:0] hex_acc;
  logic [15:0] high_sur;
  logic [15:0] pos_idx;
  logic [15:0] esc_pos;
  logic [1:0]  err_hold;
  jsu_out_t    step_bytes[$];
  jsu_out_t    utf8_expected[$];

  task automatic clear_string();
    phase    = PH_IDLE;
    hex_acc  = '0;
    high_sur = '0;
    pos_idx  = '0;
    esc_pos  = '0;
    err_hold = ERR_NONE;
  endtask

  task automatic raise(input logic [1:0] code, input logic [15:0] where);
    err_hold = code;
    esc_pos  = where;
    phase    = PH_IDLE;
  endtask

  function automatic logic [4:0] nibble_of(input logic [7:0] c);
    logic [7:0] t;
    t = 8'd16;
    if (c >= 8'h30 && c <= 8'h39) t = c - 8'h30;
    else if (c >= 8'h61 && c <= 8'h66) t = c - 8'h57;
    else if (c >= 8'h41 && c <= 8'h46) t = c - 8'h37;
    return t[4:0];
  endfunction

  task automatic add_data(input logic [7:0] b);
    jsu_out_t r;
    r.out_byte   = b;
    r.byte_valid = 1'b1;
    r.out_last   = 1'b0;
    r.error_code = ERR_NONE;
    r.error_pos  = '0;
    step_bytes.push_back(r);
  endtask

  task automatic add_code(input logic [31:0] code);
    int          n;
    logic [31:0] t;
    if (code < 32'h80) n = 1;
    else if (code < 32'h800) n = 2;
    else if (code < 32'h10000) n = 3;
    else if (code < 32'h200000) n = 4;
    else if (code < 32'h4000000) n = 5;
    else n = 6;
    if (n == 1) begin
      add_data(code[7:0]);
    end else begin
      t = (32'hFF00 >> n) | (code >> (6 * (n - 1)));
      add_data(t[7:0]);
      for (int k = 1; k < n; k++) begin
        t = code >> (6 * (n - 1 - k));
        add_data({2'b10, t[5:0]});
      end
    end
  endtask

  task automatic decode_byte(input logic [7:0] c, input logic last);
    logic [15:0] off;
    logic [15:0] st;
    logic [4:0]  dig;
    logic [7:0]  esc_val;
    logic        esc_ok;
    logic [31:0] lo;
    logic [31:0] cp;
    jsu_out_t    marker;
    off = pos_idx - esc_pos;
    st  = esc_pos;
    dig = nibble_of(c);
    step_bytes.delete();
    if (err_hold == ERR_NONE) begin
      case (phase)
        PH_IDLE: begin
          if (c == C_BSLASH) begin
            esc_pos = pos_idx;
            phase   = PH_ESC;
            if (last) raise(ERR_ESCAPE, pos_idx);
          end else begin
            add_data(c);
          end
        end
        PH_ESC: begin
          esc_ok = 1'b1;
          case (c)
            C_QUOTE:  esc_val = C_QUOTE;
            C_BSLASH: esc_val = C_BSLASH;
            C_SLASH:  esc_val = C_SLASH;
            C_LC_B:   esc_val = 8'h08;
            C_LC_F:   esc_val = 8'h0C;
            C_LC_N:   esc_val = 8'h0A;
            C_LC_R:   esc_val = 8'h0D;
            C_LC_T:   esc_val = 8'h09;
            default: begin
              esc_ok  = 1'b0;
              esc_val = '0;
            end
          endcase
          if (esc_ok) begin
            add_data(esc_val);
            phase = PH_IDLE;
          end else if (c == C_LC_U && !last) begin
            hex_acc = '0;
            phase   = PH_UHEX;
          end else begin
            raise(ERR_ESCAPE, st);
          end
        end
        PH_UHEX: begin
          if (off == OFF_PLUS && c == C_PLUS) begin
            if (!ext_en || last) begin
              raise(ERR_ESCAPE, st);
            end else begin
              hex_acc = '0;
              phase   = PH_XHEX;
            end
          end else begin
            if (dig[4]) phase = PH_BADU;
            else hex_acc = {hex_acc[27:0], dig[3:0]};
            if (off >= OFF_U_END) begin
              if (phase == PH_BADU) begin
                raise(ERR_HEX, st + POS_U_HEX);
              end else if (hex_acc[15:0] >= HI_MIN && hex_acc[15:0] <= HI_MAX) begin
                high_sur = hex_acc[15:0];
                phase    = PH_SKIP;
                if (last) raise(ERR_SURROGATE, st);
              end else begin
                add_code({16'h0, hex_acc[15:0]});
                phase = PH_IDLE;
              end
            end else if (last) begin
              raise(ERR_ESCAPE, st);
            end
          end
        end
        PH_BADU: begin
          if (off >= OFF_U_END) raise(ERR_HEX, st + POS_U_HEX);
          else if (last) raise(ERR_ESCAPE, st);
        end
        PH_XHEX: begin
          if (dig[4]) phase = PH_BADX;
          else hex_acc = {hex_acc[27:0], dig[3:0]};
          if (off >= OFF_X_END) begin
            if (phase == PH_BADX) begin
              raise(ERR_HEX, st + POS_X_HEX);
            end else if (hex_acc[31]) begin
              raise(ERR_ESCAPE, st);
            end else begin
              add_code(hex_acc);
              phase = PH_IDLE;
            end
          end else if (last) begin
            raise(ERR_ESCAPE, st);
          end
        end
        PH_BADX: begin
          if (off >= OFF_X_END) raise(ERR_HEX, st + POS_X_HEX);
          else if (last) raise(ERR_ESCAPE, st);
        end
        PH_SKIP: begin
          if (off >= OFF_SKIP_END) begin
            hex_acc = '0;
            phase   = PH_LOWHEX;
          end
          if (last) raise(ERR_SURROGATE, st);
        end
        PH_LOWHEX: begin
          if (dig[4]) phase = PH_BADLOW;
          else hex_acc = {hex_acc[27:0], dig[3:0]};
          if (off >= OFF_LOW_END) begin
            lo = {16'h0, hex_acc[15:0]};
            if (phase == PH_BADLOW) begin
              raise(ERR_HEX, st + POS_LOW_HEX);
            end else if (lo < {16'h0, LO_MIN} || lo > {16'h0, LO_MAX}) begin
              raise(ERR_SURROGATE, st);
            end else begin
              cp = ((({16'h0, high_sur} - {16'h0, HI_MIN}) << 10) | (lo - {16'h0, LO_MIN}))
                   + 32'h10000;
              add_code(cp);
              phase = PH_IDLE;
            end
          end else if (last) begin
            raise(ERR_SURROGATE, st);
          end
        end
        PH_BADLOW: begin
          if (off >= OFF_LOW_END) raise(ERR_HEX, st + POS_LOW_HEX);
          else if (last) raise(ERR_SURROGATE, st);
        end
        default: phase = PH_IDLE;
      endcase
    end
    pos_idx = pos_idx + 16'd1;
    if (last) begin
      if (step_bytes.size() == 0) begin
        marker.out_byte   = '0;
        marker.byte_valid = 1'b0;
        marker.out_last   = 1'b0;
        marker.error_code = err_hold;
        marker.error_pos  = (err_hold != ERR_NONE) ? esc_pos : '0;
        step_bytes.push_back(marker);
      end
      step_bytes[step_bytes.size() - 1].out_last = 1'b1;
      clear_string();
    end
    foreach (step_bytes[i]) utf8_expected.push_back(step_bytes[i]);
  endtask

  task automatic note_mismatch(input string what, input jsu_out_t want, input jsu_out_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("utf8 %s: exp %02h v%0d l%0d e%0d p%0d, got %02h v%0d l%0d e%0d p%0d",
               what, want.out_byte, want.byte_valid, want.out_last, want.error_code,
               want.error_pos, got.out_byte, got.byte_valid, got.out_last, got.error_code,
               got.error_pos);
  endtask

  always @(posedge clk) begin
    jsu_out_t want;
    if (rst) begin
      ext_en = 1'b1;
      clear_string();
      utf8_expected.delete();
      mismatches = 0;
    end else begin
      if (utf8_valid && utf8_ready) begin
        if (utf8_expected.size() == 0) begin
          note_mismatch("unexpected transfer", '0, utf8_data);
        end else begin
          want = utf8_expected.pop_front();
          if (want.out_byte !== utf8_data.out_byte || want.byte_valid !== utf8_data.byte_valid ||
              want.out_last !== utf8_data.out_last || want.error_code !== utf8_data.error_code ||
              want.error_pos !== utf8_data.error_pos)
            note_mismatch("mismatch", want, utf8_data);
        end
      end
      if (cfg_valid && cfg_ready) ext_en = cfg_data;
      if (text_valid && text_ready) decode_byte(text_data.in_byte, text_data.in_last);
    end
    pending = utf8_expected.size();
  end

endmodule

// File: sim/testbench.sv
// Top of the unescaper testbench: clock, reset, string stimulus, output stalls and verdict.
module testbench;
  import jsu_pkg::*;

  localparam int QUIET_LIMIT  = 3000;
  localparam int STALL_CYCLES = 400;

  logic        clk = 1'b0;
  logic        rst;
  logic        calm;
  int          stall_asked;
  int          sent_bytes;
  int          quiet;
  int unsigned mismatches;
  int unsigned pending;
  logic [7:0]  str_q[$];

  jsu_chan_if #(.payload_t(jsu_in_t))  text_ch ();
  jsu_chan_if #(.payload_t(logic))     cfg_ch ();
  jsu_chan_if #(.payload_t(jsu_out_t)) utf8_ch ();

  json_string_unescaper u_top (
    .clk  (clk),
    .rst  (rst),
    .text (text_ch),
    .cfg  (cfg_ch),
    .utf8 (utf8_ch)
  );

  unescape_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .text_valid (text_ch.valid),
    .text_ready (text_ch.ready),
    .text_data  (text_ch.data),
    .cfg_valid  (cfg_ch.valid),
    .cfg_ready  (cfg_ch.ready),
    .cfg_data   (cfg_ch.data),
    .utf8_valid (utf8_ch.valid),
    .utf8_ready (utf8_ch.ready),
    .utf8_data  (utf8_ch.data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (text_ch.valid && text_ch.ready) || (cfg_ch.valid && cfg_ch.ready) ||
        (utf8_ch.valid && utf8_ch.ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // receiver: random back-pressure or none when calm, long hold-off on request
  initial begin
    int stall_left;
    int stall_done;
    stall_left    = 0;
    stall_done    = 0;
    utf8_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_asked != stall_done) begin
        stall_left = STALL_CYCLES;
        stall_done = stall_asked;
      end
      if (stall_left > 0) begin
        utf8_ch.ready <= 1'b0;
        stall_left--;
      end else if (calm) begin
        utf8_ch.ready <= 1'b1;
      end else begin
        utf8_ch.ready <= ($urandom_range(99) >= 17);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    jsu_in_t item;
    item.in_byte = b;
    item.in_last = last;
    while (!calm && $urandom_range(99) < 17) begin
      text_ch.valid <= 1'b0;
      @(negedge clk);
    end
    text_ch.valid <= 1'b1;
    text_ch.data  <= item;
    do @(posedge clk); while (!text_ch.ready);
    @(negedge clk);
    sent_bytes++;
  endtask

  task automatic send_string();
    for (int i = 0; i < str_q.size(); i++) send_byte(str_q[i], i == str_q.size() - 1);
  endtask

  task automatic send_text(input string s);
    str_q.delete();
    for (int i = 0; i < s.len(); i++) str_q.push_back(s[i]);
    send_string();
  endtask

  // hold the sender until every expected byte has come out, then let the decoder settle
  task automatic drain();
    text_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_cfg(input logic v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    return (b == C_BSLASH) ? 8'h5B : b;
  endfunction

  function automatic logic [7:0] simple_letter();
    case ($urandom_range(7))
      0:       return C_QUOTE;
      1:       return C_BSLASH;
      2:       return C_SLASH;
      3:       return C_LC_B;
      4:       return C_LC_F;
      5:       return C_LC_N;
      6:       return C_LC_R;
      default: return C_LC_T;
    endcase
  endfunction

  function automatic logic [7:0] non_hex();
    case ($urandom_range(7))
      0:       return 8'h2F;
      1:       return 8'h3A;
      2:       return 8'h40;
      3:       return 8'h47;
      4:       return 8'h60;
      5:       return 8'h67;
      6:       return 8'h00;
      default: return 8'hFF;
    endcase
  endfunction

  function automatic logic [15:0] bmp_value();
    case ($urandom_range(5))
      0:       return 16'($urandom_range(16'h7F));
      1:       return 16'($urandom_range(16'h7FF, 16'h80));
      2:       return 16'($urandom_range(16'hD7FF, 16'h800));
      3:       return 16'($urandom_range(LO_MAX, LO_MIN));
      4:       return 16'($urandom_range(16'hFFFF, 16'hE000));
      default: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
    endcase
  endfunction

  function automatic logic [31:0] ext_value();
    case ($urandom_range(6))
      0:       return $urandom_range(32'h7F);
      1:       return $urandom_range(32'h7FF, 32'h80);
      2:       return $urandom_range(32'hFFFF, 32'h800);
      3:       return $urandom_range(32'h1FFFFF, 32'h10000);
      4:       return $urandom_range(32'h3FFFFFF, 32'h200000);
      5:       return $urandom_range(32'h7FFFFFFF, 32'h4000000);
      default: return $urandom_range(32'hFFFFFFFF, 32'h80000000);
    endcase
  endfunction

  task automatic open_u(input logic plus);
    str_q.push_back(C_BSLASH);
    str_q.push_back(C_LC_U);
    if (plus) str_q.push_back(C_PLUS);
  endtask

  task automatic add_hex(input logic [31:0] v, input int digits);
    logic [3:0] nib;
    for (int i = digits - 1; i >= 0; i--) begin
      nib = v[4*i +: 4];
      if (nib < 4'd10) str_q.push_back(8'h30 + nib);
      else if ($urandom_range(1)) str_q.push_back(8'h57 + nib);
      else str_q.push_back(8'h37 + nib);
    end
  endtask

  task automatic add_pair();
    logic [15:0] hi;
    logic [15:0] lo;
    if ($urandom_range(3) == 0) hi = $urandom_range(1) ? HI_MAX : HI_MIN;
    else hi = 16'($urandom_range(HI_MAX, HI_MIN));
    open_u(1'b0);
    add_hex({16'h0, hi}, 4);
    if ($urandom_range(99) < 85) begin
      open_u(1'b0);
    end else begin
      str_q.push_back(plain_byte());
      str_q.push_back(plain_byte());
    end
    if ($urandom_range(99) >= 85) lo = 16'($urandom_range(16'hFFFF));
    else if ($urandom_range(3) == 0) lo = $urandom_range(1) ? LO_MAX : LO_MIN;
    else lo = 16'($urandom_range(LO_MAX, LO_MIN));
    add_hex({16'h0, lo}, 4);
  endtask

  task automatic add_token();
    int pick;
    int at;
    int k;
    pick = int'($urandom_range(99));
    at   = str_q.size();
    if (pick < 25) begin
      repeat ($urandom_range(1, 3)) str_q.push_back(plain_byte());
    end else if (pick < 40) begin
      str_q.push_back(C_BSLASH);
      str_q.push_back(simple_letter());
    end else if (pick < 58) begin
      open_u(1'b0);
      add_hex({16'h0, bmp_value()}, 4);
    end else if (pick < 70) begin
      add_pair();
    end else if (pick < 85) begin
      open_u(1'b1);
      add_hex(ext_value(), 8);
    end else if (pick < 93) begin
      str_q.push_back(C_BSLASH);
      str_q.push_back(8'($urandom_range(255)));
    end else begin
      case ($urandom_range(2))
        0: begin
          open_u(1'b0);
          add_hex({16'h0, bmp_value()}, 4);
          k = at + 2 + int'($urandom_range(3));
        end
        1: begin
          open_u(1'b1);
          add_hex(ext_value(), 8);
          k = at + 3 + int'($urandom_range(7));
        end
        default: begin
          add_pair();
          k = at + 8 + int'($urandom_range(3));
        end
      endcase
      str_q[k] = non_hex();
    end
  endtask

  task automatic make_string();
    int mark;
    int cut;
    mark = 0;
    str_q.delete();
    repeat ($urandom_range(1, 6)) begin
      mark = str_q.size();
      add_token();
    end
    // cut the final token short now and then
    if ($urandom_range(99) < 12 && str_q.size() > mark + 1) begin
      cut = int'($urandom_range(str_q.size() - 1, mark + 1));
      while (str_q.size() > cut) void'(str_q.pop_back());
    end
  endtask

  task automatic random_phase(input int goal);
    int target;
    target = sent_bytes + goal;
    while (sent_bytes < target) begin
      make_string();
      send_string();
    end
  endtask

  initial begin
    rst           = 1'b1;
    calm          = 1'b0;
    stall_asked   = 0;
    sent_bytes    = 0;
    text_ch.valid = 1'b0;
    text_ch.data  = '0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.data   = 1'b0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    str_q = {8'h00, 8'hFF};
    send_string();
    send_text("\\uD83D\\uDE00");
    send_text("\\u+7FFFFFFF");
    send_text("\\q");

    drain();
    write_cfg(1'b1);
    stall_asked <= stall_asked + 1;
    random_phase(100);

    drain();
    write_cfg(1'b0);
    random_phase(90);

    // no idling on either side, starting with a bad hex field
    calm <= 1'b1;
    drain();
    send_text("ab\\u1G34cd");
    random_phase(50);
    drain();
    calm <= 1'b0;

    write_cfg(1'b1);
    stall_asked <= stall_asked + 1;
    random_phase(80);

    drain();
    write_cfg(1'b0);
    random_phase(70);

    drain();
    repeat (12) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: json_string_unescaper.f
hw/rtl/jsu_pkg.sv
hw/rtl/jsu_chan_if.sv
hw/rtl/jsu_decoder.sv
hw/rtl/jsu_burst_buf.sv
hw/rtl/json_string_unescaper.sv
sim/unescape_checker.sv
sim/testbench.sv
